// ----- rtl/core/mdm_pkg.sv -----
// Shared types, constants and the control program of the desaturating motor mixer.
// No dependencies; used by mdm_div.sv and multirotor_desaturating_mixer_top.sv.
package mdm_pkg;

	localparam int SLOTS      = 4;
	localparam int ROTORS_DEF = 4;
	localparam int SCALE_W    = 16;
	localparam int CMD_W      = 16;
	localparam int THR_W      = 15;
	localparam int MOT_W      = 26;
	localparam int GAIN_W     = 33;
	localparam int NUM_W      = 38;
	localparam int DEN_W      = 16;
	localparam int K_W        = NUM_W + 1;
	localparam int PROD_W     = GAIN_W + SCALE_W;
	localparam int ACC_W      = PROD_W + 1;
	localparam int SUM_W      = MOT_W + 11;
	localparam int OUT_W      = 18;
	localparam int PC_W       = 6;
	localparam int IDX_W      = 3;
	localparam int DATA_W     = 64;

	localparam logic signed [MOT_W-1:0] ONE_Q14   = 26'sd16384;
	localparam logic signed [MOT_W-1:0] YAW_LIMIT = 26'sd18842;
	localparam logic signed [SUM_W-1:0] INT_LIM   = 37'sd16777216;
	localparam logic signed [GAIN_W-1:0] GAIN_MAX = 33'sd2147483648;
	localparam logic signed [GAIN_W-1:0] GAIN_MIN = -33'sd2147483648;
	localparam logic signed [MOT_W-1:0] OUT_MAX   = 26'sd131071;
	localparam logic signed [MOT_W-1:0] OUT_MIN   = -26'sd131072;

	localparam logic [1:0] AX_ROLL   = 2'd0;
	localparam logic [1:0] AX_PITCH  = 2'd1;
	localparam logic [1:0] AX_YAW    = 2'd2;
	localparam logic [1:0] AX_THRUST = 2'd3;

	localparam logic [IDX_W-1:0] REG_AIRMODE = 3'd0;
	localparam logic [IDX_W-1:0] REG_GEOM0   = 3'd1;
	localparam logic [IDX_W-1:0] REG_GEOM1   = 3'd2;
	localparam logic [IDX_W-1:0] REG_GEOM2   = 3'd3;
	localparam logic [IDX_W-1:0] REG_GEOM3   = 3'd4;

	localparam logic [1:0] AIR_RP  = 2'd1;
	localparam logic [1:0] AIR_RPY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MUL, ST_ACC, ST_GCHK, ST_DIV, ST_GUPD, ST_GEND
	} state_t;

	typedef enum logic [3:0] {
		OP_JAM1, OP_JAM2, OP_JMP, OP_JPOS, OP_MIX, OP_YAWADD, OP_GAIN, OP_APPLY, OP_DONE
	} op_t;

	typedef enum logic {LIM_ONE, LIM_YAW} lim_t;

	typedef struct packed {
		op_t             op;
		logic [1:0]      ax;
		lim_t            lim;
		logic            half;
		logic            with_yaw;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Divider handshake between the sequencer and the serial divider.
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	localparam logic [PC_W-1:0] PC_RP  = 6'd17;
	localparam logic [PC_W-1:0] PC_RPY = 6'd23;
	localparam logic [PC_W-1:0] PC_YAW = 6'd33;

	function automatic ctrl_t c_op(input op_t op, input logic [1:0] ax, input lim_t lim,
		input logic half, input logic with_yaw, input logic [PC_W-1:0] target);
		ctrl_t c;
		c.op = op;
		c.ax = ax;
		c.lim = lim;
		c.half = half;
		c.with_yaw = with_yaw;
		c.target = target;
		return c;
	endfunction

	function automatic ctrl_t c_gain(input logic [1:0] ax, input lim_t lim);
		return c_op(OP_GAIN, ax, lim, 1'b0, 1'b0, '0);
	endfunction

	function automatic ctrl_t c_apply(input logic [1:0] ax, input logic half);
		return c_op(OP_APPLY, ax, LIM_ONE, half, 1'b0, '0);
	endfunction

	function automatic ctrl_t c_jump(input op_t op, input logic [PC_W-1:0] target);
		return c_op(op, AX_ROLL, LIM_ONE, 1'b0, 1'b0, target);
	endfunction

	// Control program. Each pass is: gain, apply, gain again, apply half.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		unique case (pc)
			6'd0:  c = c_jump(OP_JAM1, PC_RP);
			6'd1:  c = c_jump(OP_JAM2, PC_RPY);
			6'd2:  c = c_op(OP_MIX, AX_ROLL, LIM_ONE, 1'b0, 1'b0, '0);
			6'd3:  c = c_gain(AX_THRUST, LIM_ONE);
			6'd4:  c = c_jump(OP_JPOS, 6'd8);
			6'd5:  c = c_apply(AX_THRUST, 1'b0);
			6'd6:  c = c_gain(AX_THRUST, LIM_ONE);
			6'd7:  c = c_apply(AX_THRUST, 1'b1);
			6'd8:  c = c_gain(AX_ROLL, LIM_ONE);
			6'd9:  c = c_apply(AX_ROLL, 1'b0);
			6'd10: c = c_gain(AX_ROLL, LIM_ONE);
			6'd11: c = c_apply(AX_ROLL, 1'b1);
			6'd12: c = c_gain(AX_PITCH, LIM_ONE);
			6'd13: c = c_apply(AX_PITCH, 1'b0);
			6'd14: c = c_gain(AX_PITCH, LIM_ONE);
			6'd15: c = c_apply(AX_PITCH, 1'b1);
			6'd16: c = c_jump(OP_JMP, PC_YAW);
			6'd17: c = c_op(OP_MIX, AX_ROLL, LIM_ONE, 1'b0, 1'b0, '0);
			6'd18: c = c_gain(AX_THRUST, LIM_ONE);
			6'd19: c = c_apply(AX_THRUST, 1'b0);
			6'd20: c = c_gain(AX_THRUST, LIM_ONE);
			6'd21: c = c_apply(AX_THRUST, 1'b1);
			6'd22: c = c_jump(OP_JMP, PC_YAW);
			6'd23: c = c_op(OP_MIX, AX_ROLL, LIM_ONE, 1'b0, 1'b1, '0);
			6'd24: c = c_gain(AX_THRUST, LIM_ONE);
			6'd25: c = c_apply(AX_THRUST, 1'b0);
			6'd26: c = c_gain(AX_THRUST, LIM_ONE);
			6'd27: c = c_apply(AX_THRUST, 1'b1);
			6'd28: c = c_gain(AX_YAW, LIM_ONE);
			6'd29: c = c_apply(AX_YAW, 1'b0);
			6'd30: c = c_gain(AX_YAW, LIM_ONE);
			6'd31: c = c_apply(AX_YAW, 1'b1);
			6'd32: c = c_jump(OP_DONE, '0);
			6'd33: c = c_op(OP_YAWADD, AX_YAW, LIM_ONE, 1'b0, 1'b0, '0);
			6'd34: c = c_gain(AX_YAW, LIM_YAW);
			6'd35: c = c_apply(AX_YAW, 1'b0);
			6'd36: c = c_gain(AX_YAW, LIM_YAW);
			6'd37: c = c_apply(AX_YAW, 1'b1);
			6'd38: c = c_gain(AX_THRUST, LIM_ONE);
			6'd39: c = c_jump(OP_JPOS, 6'd43);
			6'd40: c = c_apply(AX_THRUST, 1'b0);
			6'd41: c = c_gain(AX_THRUST, LIM_ONE);
			6'd42: c = c_apply(AX_THRUST, 1'b1);
			default: c = c_jump(OP_DONE, '0);
		endcase
		return c;
	endfunction

	function automatic logic signed [SCALE_W-1:0] scale_of(input logic [DATA_W-1:0] geom,
		input logic [1:0] ax);
		logic signed [SCALE_W-1:0] s;
		unique case (ax)
			AX_ROLL:   s = geom[15:0];
			AX_PITCH:  s = geom[31:16];
			AX_YAW:    s = geom[47:32];
			AX_THRUST: s = geom[63:48];
			default:   s = geom[15:0];
		endcase
		return s;
	endfunction

	function automatic logic signed [MOT_W-1:0] sat_mot(input logic signed [SUM_W-1:0] x);
		logic signed [MOT_W-1:0] y;
		if (x > INT_LIM)
			y = MOT_W'(INT_LIM);
		else if (x < -INT_LIM)
			y = MOT_W'(-INT_LIM);
		else
			y = MOT_W'(x);
		return y;
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic signed [MOT_W-1:0] x);
		logic [OUT_W-1:0] y;
		if (x > OUT_MAX)
			y = OUT_W'(OUT_MAX);
		else if (x < OUT_MIN)
			y = OUT_W'(OUT_MIN);
		else
			y = OUT_W'(x);
		return y;
	endfunction

endpackage

// ----- rtl/core/mdm_div.sv -----
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on mdm_pkg for widths and the request and response structs.
module mdm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mdm_pkg::div_req_t req,
	output mdm_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(mdm_pkg::NUM_W + 1);

	logic                           busy_q;
	logic [CNT_W-1:0]               cnt_q;
	logic [mdm_pkg::DEN_W-1:0]      rem_q;
	logic [mdm_pkg::NUM_W-1:0]      nq_q;
	logic [mdm_pkg::DEN_W-1:0]      den_q;
	logic                           done_q;
	logic [mdm_pkg::DEN_W:0]        trial;
	logic                           fits;

	// Bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, nq_q[mdm_pkg::NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(mdm_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The remainder stays below the divisor, so it fits in the divisor width.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			nq_q  <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= mdm_pkg::DEN_W'(fits ? (trial - {1'b0, den_q}) : trial);
			nq_q  <= {nq_q[mdm_pkg::NUM_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = nq_q;

endmodule

// ----- rtl/core/multirotor_desaturating_mixer_top.sv -----
// Top level of the four-rotor desaturating motor mixer: stream ports, configuration
// registers and the microcoded sequencer. Depends on mdm_pkg and mdm_div.

// One beat on the input stream carries a roll, pitch, yaw and thrust command; one beat
// on the output stream returns the four saturated Q3.14 rotor demands and the over and
// under limit flags. A small program in a constant table steps a shared datapath (one
// 33 by 16 bit multiplier, an adder with rounding and clamping, and a serial divider)
// through the mix and the desaturation passes chosen by the airmode register. The
// input is accepted only while the sequencer is idle, and the finished result sits in
// an output register so the next command can be taken while it waits. The mix visits
// every rotor and each axis it mixes, an apply every rotor, and each gain step checks
// every rotor and runs the one-bit-per-cycle divider on every rotor outside its limits,
// so the divider sets the worst case. Configuration is to be written through the plain
// write port while the block is idle; the block itself does not enforce this.
module multirotor_desaturating_mixer_top #(
	parameter int ROTORS = mdm_pkg::ROTORS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// roll_cmd[15:0], pitch_cmd[31:16], yaw_cmd[47:32], thrust_cmd[62:48], zero pad
	input  logic [63:0]                 s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// motor_0[17:0], motor_1[35:18], motor_2[53:36], motor_3[71:54],
	// motor_pos_saturated[72], motor_neg_saturated[73], zero pad
	output logic [79:0]                 m_axis_tdata,
	input  logic                        wr_en,
	input  logic [mdm_pkg::IDX_W-1:0]   wr_index,
	input  logic [mdm_pkg::DATA_W-1:0]  wr_data
);

	localparam logic [1:0] LAST = 2'(ROTORS - 1);

	mdm_pkg::state_t state_q, state_d;
	mdm_pkg::ctrl_t  ctl;

	logic [mdm_pkg::PC_W-1:0]          pc_q;
	logic [1:0]                        ri_q;
	logic [1:0]                        axc_q;
	logic [1:0]                        airmode_q;
	logic [mdm_pkg::DATA_W-1:0]        geom_q [mdm_pkg::SLOTS];
	logic signed [mdm_pkg::CMD_W-1:0]  roll_q, pitch_q, yaw_q;
	logic [mdm_pkg::THR_W-1:0]         thr_q;
	logic signed [mdm_pkg::MOT_W-1:0]  mot_q [mdm_pkg::SLOTS];
	logic signed [mdm_pkg::ACC_W-1:0]  acc_q;
	logic signed [mdm_pkg::PROD_W-1:0] prod_q;
	logic signed [mdm_pkg::GAIN_W-1:0] g_q;
	logic signed [mdm_pkg::K_W-1:0]    kmin_q, kmax_q;
	logic                              neg_q;
	logic                              flag_pos_q, flag_neg_q;
	logic [79:0]                       out_q;
	logic                              out_valid_q;

	logic                              in_beat;
	logic                              out_free;
	logic                              out_load;
	logic                              last_rotor;
	logic [1:0]                        ax_sel;
	logic signed [mdm_pkg::SCALE_W-1:0] scale;
	logic signed [mdm_pkg::GAIN_W-1:0] g_half;
	logic signed [mdm_pkg::GAIN_W-1:0] mul_a;
	logic signed [mdm_pkg::PROD_W-1:0] prod_d;
	logic signed [mdm_pkg::ACC_W-1:0]  acc_sum;
	logic signed [mdm_pkg::ACC_W-1:0]  acc_rnd;
	logic signed [mdm_pkg::SUM_W-1:0]  mix_val;
	logic signed [mdm_pkg::PROD_W-1:0] prod_rnd;
	logic signed [mdm_pkg::SUM_W-1:0]  add_val;
	logic signed [mdm_pkg::MOT_W-1:0]  mot_cur;
	logic signed [mdm_pkg::MOT_W-1:0]  hi;
	logic signed [mdm_pkg::MOT_W-1:0]  lim_v;
	logic signed [mdm_pkg::MOT_W-1:0]  diff;
	logic signed [mdm_pkg::K_W-1:0]    num_s;
	logic                              below, above, hit;
	logic signed [mdm_pkg::K_W-1:0]    k_val;
	logic signed [mdm_pkg::K_W:0]      k_sum;
	logic signed [mdm_pkg::GAIN_W-1:0] g_new;
	mdm_pkg::div_req_t                 dreq;
	mdm_pkg::div_rsp_t                 drsp;

	mdm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign ctl           = mdm_pkg::ucode(pc_q);
	assign s_axis_tready = (state_q == mdm_pkg::ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == mdm_pkg::ST_EXEC) && (ctl.op == mdm_pkg::OP_DONE)
		&& out_free;
	assign last_rotor    = (ri_q == LAST);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	// Axis whose scale feeds the datapath this cycle.
	always_comb begin
		if (ctl.op == mdm_pkg::OP_MIX)
			ax_sel = axc_q;
		else if (ctl.op == mdm_pkg::OP_YAWADD)
			ax_sel = mdm_pkg::AX_YAW;
		else
			ax_sel = ctl.ax;
	end

	assign scale   = mdm_pkg::scale_of(geom_q[ri_q], ax_sel);
	assign mot_cur = mot_q[ri_q];

	// Half gain truncated toward zero.
	assign g_half = $signed(g_q + mdm_pkg::GAIN_W'(g_q[mdm_pkg::GAIN_W-1])) >>> 1;

	always_comb begin
		mul_a = g_q;
		if (ctl.op == mdm_pkg::OP_MIX) begin
			unique case (axc_q)
				mdm_pkg::AX_ROLL:   mul_a = mdm_pkg::GAIN_W'(roll_q);
				mdm_pkg::AX_PITCH:  mul_a = mdm_pkg::GAIN_W'(pitch_q);
				mdm_pkg::AX_YAW:    mul_a = mdm_pkg::GAIN_W'(yaw_q);
				mdm_pkg::AX_THRUST: mul_a = $signed(mdm_pkg::GAIN_W'(thr_q));
				default:            mul_a = mdm_pkg::GAIN_W'(roll_q);
			endcase
		end else if (ctl.op == mdm_pkg::OP_YAWADD) begin
			mul_a = mdm_pkg::GAIN_W'(yaw_q);
		end else if (ctl.half) begin
			mul_a = g_half;
		end
	end

	assign prod_d = mul_a * scale;

	// Rounding to Q.14 is a floor shift after adding half an LSB.
	assign acc_sum  = acc_q + mdm_pkg::ACC_W'(prod_q);
	assign acc_rnd  = (acc_sum + mdm_pkg::ACC_W'(4096)) >>> 13;
	assign mix_val  = mdm_pkg::SUM_W'(acc_rnd);
	assign prod_rnd = (prod_q + mdm_pkg::PROD_W'(4096)) >>> 13;
	assign add_val  = mdm_pkg::SUM_W'(mot_cur) + mdm_pkg::SUM_W'(prod_rnd);

	// Per-rotor gain: the rotor is outside its limit, the quotient is taken on magnitudes.
	assign hi    = (ctl.lim == mdm_pkg::LIM_YAW) ? mdm_pkg::YAW_LIMIT : mdm_pkg::ONE_Q14;
	assign below = mot_cur[mdm_pkg::MOT_W-1];
	assign above = mot_cur > hi;
	assign hit   = (scale != '0) && (below || above);
	assign lim_v = below ? '0 : hi;
	assign diff  = lim_v - mot_cur;
	assign num_s = mdm_pkg::K_W'(diff) <<< 13;

	always_comb begin
		dreq.start = (state_q == mdm_pkg::ST_GCHK) && hit;
		dreq.num   = num_s[mdm_pkg::K_W-1] ? mdm_pkg::NUM_W'(-num_s) : mdm_pkg::NUM_W'(num_s);
		dreq.den   = scale[mdm_pkg::SCALE_W-1] ? mdm_pkg::DEN_W'(-scale)
			: mdm_pkg::DEN_W'(scale);
	end

	assign k_val = neg_q ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});
	assign k_sum = mdm_pkg::K_W'(0) + (mdm_pkg::K_W + 1)'(kmin_q) + (mdm_pkg::K_W + 1)'(kmax_q);

	always_comb begin
		if (k_sum > (mdm_pkg::K_W + 1)'(mdm_pkg::GAIN_MAX))
			g_new = mdm_pkg::GAIN_MAX;
		else if (k_sum < (mdm_pkg::K_W + 1)'(mdm_pkg::GAIN_MIN))
			g_new = mdm_pkg::GAIN_MIN;
		else
			g_new = mdm_pkg::GAIN_W'(k_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mdm_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mdm_pkg::ST_IDLE: begin
				if (in_beat)
					state_d = mdm_pkg::ST_EXEC;
			end
			mdm_pkg::ST_EXEC: begin
				unique case (ctl.op)
					mdm_pkg::OP_MIX, mdm_pkg::OP_YAWADD, mdm_pkg::OP_APPLY:
						state_d = mdm_pkg::ST_MUL;
					mdm_pkg::OP_GAIN:
						state_d = mdm_pkg::ST_GCHK;
					mdm_pkg::OP_DONE: begin
						if (out_free)
							state_d = mdm_pkg::ST_IDLE;
					end
					default: state_d = mdm_pkg::ST_EXEC;
				endcase
			end
			mdm_pkg::ST_MUL: state_d = mdm_pkg::ST_ACC;
			mdm_pkg::ST_ACC: begin
				if (ctl.op == mdm_pkg::OP_MIX && axc_q != mdm_pkg::AX_THRUST)
					state_d = mdm_pkg::ST_MUL;
				else if (last_rotor)
					state_d = mdm_pkg::ST_EXEC;
				else
					state_d = mdm_pkg::ST_MUL;
			end
			mdm_pkg::ST_GCHK: begin
				if (hit)
					state_d = mdm_pkg::ST_DIV;
				else if (last_rotor)
					state_d = mdm_pkg::ST_GEND;
			end
			mdm_pkg::ST_DIV: begin
				if (drsp.done)
					state_d = mdm_pkg::ST_GUPD;
			end
			mdm_pkg::ST_GUPD:
				state_d = last_rotor ? mdm_pkg::ST_GEND : mdm_pkg::ST_GCHK;
			mdm_pkg::ST_GEND: state_d = mdm_pkg::ST_EXEC;
			default: state_d = mdm_pkg::ST_IDLE;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			airmode_q <= '0;
			for (int i = 0; i < mdm_pkg::SLOTS; i++)
				geom_q[i] <= '0;
		end else if (wr_en) begin
			if (wr_index == mdm_pkg::REG_AIRMODE)
				airmode_q <= wr_data[1:0];
			else if (wr_index >= mdm_pkg::REG_GEOM0 && wr_index <= mdm_pkg::REG_GEOM3)
				geom_q[2'(wr_index - mdm_pkg::REG_GEOM0)] <= wr_data;
		end
	end

	// Output beat valid: set when the final step loads a result, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	// Sequencer control: program counter, rotor and axis counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= '0;
			ri_q        <= '0;
			axc_q       <= '0;
		end else begin
			unique case (state_q)
				mdm_pkg::ST_IDLE: begin
					if (in_beat)
						pc_q <= '0;
				end
				mdm_pkg::ST_EXEC: begin
					ri_q  <= '0;
					axc_q <= mdm_pkg::AX_ROLL;
					unique case (ctl.op)
						mdm_pkg::OP_JAM1:
							pc_q <= (airmode_q == mdm_pkg::AIR_RP) ? ctl.target : pc_q + 1'b1;
						mdm_pkg::OP_JAM2:
							pc_q <= (airmode_q == mdm_pkg::AIR_RPY) ? ctl.target : pc_q + 1'b1;
						mdm_pkg::OP_JMP:
							pc_q <= ctl.target;
						mdm_pkg::OP_JPOS:
							pc_q <= (!g_q[mdm_pkg::GAIN_W-1] && g_q != '0) ? ctl.target
								: pc_q + 1'b1;
						default: ;
					endcase
				end
				mdm_pkg::ST_ACC: begin
					if (ctl.op == mdm_pkg::OP_MIX && axc_q != mdm_pkg::AX_THRUST) begin
						// Roll and pitch, then yaw only for a full mix, then thrust.
						if (axc_q == mdm_pkg::AX_PITCH && !ctl.with_yaw)
							axc_q <= mdm_pkg::AX_THRUST;
						else
							axc_q <= axc_q + 1'b1;
					end else begin
						axc_q <= mdm_pkg::AX_ROLL;
						if (last_rotor)
							pc_q <= pc_q + 1'b1;
						else
							ri_q <= ri_q + 1'b1;
					end
				end
				mdm_pkg::ST_GCHK: begin
					if (!hit && !last_rotor)
						ri_q <= ri_q + 1'b1;
				end
				mdm_pkg::ST_GUPD: begin
					if (!last_rotor)
						ri_q <= ri_q + 1'b1;
				end
				mdm_pkg::ST_GEND: pc_q <= pc_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			mdm_pkg::ST_IDLE: begin
				if (in_beat) begin
					roll_q     <= s_axis_tdata[15:0];
					pitch_q    <= s_axis_tdata[31:16];
					yaw_q      <= s_axis_tdata[47:32];
					thr_q      <= s_axis_tdata[62:48];
					flag_pos_q <= 1'b0;
					flag_neg_q <= 1'b0;
					for (int i = 0; i < mdm_pkg::SLOTS; i++)
						mot_q[i] <= '0;
				end
			end
			mdm_pkg::ST_EXEC: begin
				acc_q  <= '0;
				kmin_q <= '0;
				kmax_q <= '0;
				if (out_load) begin
					out_q <= {6'b0, flag_neg_q, flag_pos_q,
						mdm_pkg::sat_out(mot_q[3]), mdm_pkg::sat_out(mot_q[2]),
						mdm_pkg::sat_out(mot_q[1]), mdm_pkg::sat_out(mot_q[0])};
				end
			end
			mdm_pkg::ST_MUL: prod_q <= prod_d;
			mdm_pkg::ST_ACC: begin
				if (ctl.op == mdm_pkg::OP_MIX) begin
					if (axc_q == mdm_pkg::AX_THRUST) begin
						mot_q[ri_q] <= mdm_pkg::sat_mot(mix_val);
						acc_q       <= '0;
					end else begin
						acc_q <= acc_sum;
					end
				end else begin
					mot_q[ri_q] <= mdm_pkg::sat_mot(add_val);
				end
			end
			mdm_pkg::ST_GCHK: begin
				if (hit) begin
					neg_q <= diff[mdm_pkg::MOT_W-1] ^ scale[mdm_pkg::SCALE_W-1];
					if (below)
						flag_neg_q <= 1'b1;
					if (above)
						flag_pos_q <= 1'b1;
				end
			end
			mdm_pkg::ST_GUPD: begin
				if (k_val < kmin_q)
					kmin_q <= k_val;
				if (k_val > kmax_q)
					kmax_q <= k_val;
			end
			mdm_pkg::ST_GEND: g_q <= g_new;
			default: ;
		endcase
	end

	// A gain update follows only a finished division.
	a_gupd_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mdm_pkg::ST_GUPD |-> $past(drsp.done))
		else $error("gain update without a finished division");

	// An accepted command restarts the program at its first step.
	a_start_prog: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == mdm_pkg::ST_EXEC) && (pc_q == '0))
		else $error("program did not restart on an input beat");

	// A division is started only from the gain check of an out-of-limit rotor.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |=> state_q == mdm_pkg::ST_DIV)
		else $error("divider started outside a gain step");

	// Output register is loaded only on the final program step.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == mdm_pkg::ST_EXEC && ctl.op == mdm_pkg::OP_DONE))
		else $error("result presented outside the final step");

endmodule

// ----- tb/sv/multirotor_desaturating_mixer_top_tb.sv -----
// Self-checking testbench for the four-rotor desaturating motor mixer.
// Checks the mix and desaturation results against a behavioral predictor.
// Depends on mdm_pkg and multirotor_desaturating_mixer_top.
`timescale 1ns / 100ps

module multirotor_desaturating_mixer_top_tb;

	localparam int NROT = 4;
	localparam longint INT_CLAMP = 64'sd16777216;
	localparam longint GAIN_CLAMP = 64'sd2147483648;
	localparam longint LIMIT_ONE = 64'sd16384;
	localparam longint LIMIT_YAW = 64'sd18842;
	localparam int CYCLE_LIMIT = 20000000;
	// An index past the register list; writes to it are ignored.
	localparam logic [2:0] REG_NONE = 3'd7;

	// One row of the directed table. A row either writes a register or sends a command.
	// When has_exp is set the typed-in result must match the predictor too.
	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [63:0] val;
		logic [62:0] cmd;
		bit          has_exp;
		logic [73:0] exp_res;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// roll_cmd[15:0], pitch_cmd[31:16], yaw_cmd[47:32], thrust_cmd[62:48], zero pad
	logic [63:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// motor_0..3 in 18-bit slices from bit 0, pos flag [72], neg flag [73], zero pad
	logic [79:0] m_axis_tdata;
	logic        wr_en;
	logic [2:0]  wr_index;
	logic [63:0] wr_data;

	// Predictor copy of the configuration.
	logic [1:0]  airmode_q;
	logic [63:0] geom_q [NROT];

	// Predictor working values.
	longint      mot_v [NROT];
	bit          fl_pos, fl_neg;

	logic [73:0] motor_results_q [$];
	int          errors;
	int          cycles;
	int          beats_out;
	int          beats_in;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off;

	multirotor_desaturating_mixer_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic longint scale_at(int r, logic [1:0] ax);
		logic signed [15:0] s;
		s = geom_q[r][16*ax +: 16];
		return longint'(s);
	endfunction

	// Floor division by 8192 after adding half: round half toward plus infinity.
	function automatic longint rnd13(longint x);
		return (x + 4096) >>> 13;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// Correction gain along one axis: sum of smallest and largest per-rotor gains.
	function automatic longint axis_gain(logic [1:0] ax, longint hi);
		longint kmin, kmax, k, d;
		kmin = 0;
		kmax = 0;
		for (int i = 0; i < NROT; i++) begin
			d = scale_at(i, ax);
			if (d != 0) begin
				if (mot_v[i] < 0) begin
					k = ((0 - mot_v[i]) * 8192) / d;
					if (k < kmin) kmin = k;
					if (k > kmax) kmax = k;
					fl_neg = 1'b1;
				end
				if (mot_v[i] > hi) begin
					k = ((hi - mot_v[i]) * 8192) / d;
					if (k < kmin) kmin = k;
					if (k > kmax) kmax = k;
					fl_pos = 1'b1;
				end
			end
		end
		return clip(kmin + kmax, -GAIN_CLAMP, GAIN_CLAMP);
	endfunction

	function automatic void apply_gain(logic [1:0] ax, longint g);
		for (int i = 0; i < NROT; i++)
			mot_v[i] = clip(mot_v[i] + rnd13(g * scale_at(i, ax)), -INT_CLAMP, INT_CLAMP);
	endfunction

	function automatic void desat_pass(logic [1:0] ax, longint hi, bit lower_only);
		longint g;
		g = axis_gain(ax, hi);
		if (!(lower_only && g > 0)) begin
			apply_gain(ax, g);
			g = axis_gain(ax, hi);
			apply_gain(ax, g / 2);
		end
	endfunction

	function automatic void mix_cmds(longint r, longint p, longint y, longint t, bit with_yaw);
		longint acc;
		for (int i = 0; i < NROT; i++) begin
			acc = r * scale_at(i, mdm_pkg::AX_ROLL) + p * scale_at(i, mdm_pkg::AX_PITCH)
				+ t * scale_at(i, mdm_pkg::AX_THRUST);
			if (with_yaw)
				acc += y * scale_at(i, mdm_pkg::AX_YAW);
			mot_v[i] = clip(rnd13(acc), -INT_CLAMP, INT_CLAMP);
		end
	endfunction

	function automatic void yaw_stage(longint y);
		for (int i = 0; i < NROT; i++)
			mot_v[i] = clip(mot_v[i] + rnd13(y * scale_at(i, mdm_pkg::AX_YAW)),
				-INT_CLAMP, INT_CLAMP);
		desat_pass(mdm_pkg::AX_YAW, LIMIT_YAW, 1'b0);
		desat_pass(mdm_pkg::AX_THRUST, LIMIT_ONE, 1'b1);
	endfunction

	function automatic logic [73:0] predict_motors(logic [62:0] cmd);
		longint r, p, y, t;
		logic [73:0] res;
		r = longint'($signed(cmd[15:0]));
		p = longint'($signed(cmd[31:16]));
		y = longint'($signed(cmd[47:32]));
		t = longint'(cmd[62:48]);
		fl_pos = 1'b0;
		fl_neg = 1'b0;
		if (airmode_q == mdm_pkg::AIR_RP) begin
			mix_cmds(r, p, y, t, 1'b0);
			desat_pass(mdm_pkg::AX_THRUST, LIMIT_ONE, 1'b0);
			yaw_stage(y);
		end else if (airmode_q == mdm_pkg::AIR_RPY) begin
			mix_cmds(r, p, y, t, 1'b1);
			desat_pass(mdm_pkg::AX_THRUST, LIMIT_ONE, 1'b0);
			desat_pass(mdm_pkg::AX_YAW, LIMIT_ONE, 1'b0);
		end else begin
			// Disabled, and the unused code, which behaves the same way.
			mix_cmds(r, p, y, t, 1'b0);
			desat_pass(mdm_pkg::AX_THRUST, LIMIT_ONE, 1'b1);
			desat_pass(mdm_pkg::AX_ROLL, LIMIT_ONE, 1'b0);
			desat_pass(mdm_pkg::AX_PITCH, LIMIT_ONE, 1'b0);
			yaw_stage(y);
		end
		for (int i = 0; i < NROT; i++)
			res[18*i +: 18] = 18'(clip(mot_v[i], -64'sd131072, 64'sd131071));
		res[72] = fl_pos;
		res[73] = fl_neg;
		return res;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic tick();
		@(posedge clk);
		cycles++;
	endtask

	// Configuration writes happen only while the block is idle. The enable drops again
	// after each write.
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		tick();
		wr_en <= 1'b0;
		if (idx == mdm_pkg::REG_AIRMODE)
			airmode_q = val[1:0];
		else if (idx >= mdm_pkg::REG_GEOM0 && idx <= mdm_pkg::REG_GEOM3)
			geom_q[idx - mdm_pkg::REG_GEOM0] = val;
		tick();
	endtask

	// Offers one command beat, with random idle cycles before it, and records the
	// predicted result when the beat is taken. Valid stays high into the next beat
	// unless the sender idles or the stream is drained.
	task automatic send_cmd(logic [62:0] cmd);
		if ($urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do tick(); while ($urandom_range(99, 0) < send_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, cmd};
		do tick(); while (!s_axis_tready);
		beats_in++;
		motor_results_q.push_back(predict_motors(cmd));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (motor_results_q.size() != 0)
			tick();
		// The block takes nothing unanswered, so a short settle is enough here.
		repeat (20) tick();
	endtask

	function automatic logic [15:0] rand_cmd16();
		case ($urandom_range(9, 0))
			0: return 16'h4000;
			1: return 16'hC000;
			2: return 16'($urandom());
			default: return 16'($signed($urandom_range(32768, 0)) - 16384);
		endcase
	endfunction

	function automatic logic [62:0] rand_cmd();
		logic [14:0] t;
		t = ($urandom_range(9, 0) == 0) ? 15'($urandom()) : 15'($urandom_range(16384, 0));
		return {t, rand_cmd16(), rand_cmd16(), rand_cmd16()};
	endfunction

	// Quad-X like geometry with random magnitudes, or fully random words.
	function automatic logic [63:0] rand_geom(int r);
		logic signed [15:0] a;
		if ($urandom_range(3, 0) == 0)
			return {$urandom(), $urandom()};
		a = 16'($urandom_range(8192, 2048));
		return {16'($urandom_range(8192, 4096)),
			(r[0] ? a : -a), (r[1] ? a : -a), (r[0] ^ r[1] ? a : -a)};
	endfunction

	// ---------------------------------------------------------------- receiver

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_out++;
				if (motor_results_q.size() == 0) begin
					$display("%0t: unexpected result beat %h", $time, m_axis_tdata);
					errors++;
				end else begin
					logic [73:0] want;
					want = motor_results_q.pop_front();
					for (int i = 0; i < 4; i++)
						if (m_axis_tdata[18*i +: 18] !== want[18*i +: 18]) begin
							$display("%0t: motor_%0d expected %h actual %h", $time, i,
								want[18*i +: 18], m_axis_tdata[18*i +: 18]);
							errors++;
						end
					if (m_axis_tdata[73:72] !== want[73:72]) begin
						$display("%0t: flags neg,pos expected %b actual %b", $time,
							want[73:72], m_axis_tdata[73:72]);
						errors++;
					end
					if (m_axis_tdata[79:74] !== 6'd0) begin
						$display("%0t: pad expected 0 actual %h", $time, m_axis_tdata[79:74]);
						errors++;
					end
				end
			end
			m_axis_tready <= !hold_off && ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	row_t table_rows [$];

	function automatic row_t cfg_row(logic [2:0] idx, logic [63:0] val);
		row_t rw;
		rw = '{default: '0};
		rw.is_cfg = 1'b1;
		rw.idx = idx;
		rw.val = val;
		return rw;
	endfunction

	function automatic row_t cmd_row(logic [62:0] cmd, bit has_exp, logic [73:0] exp_res);
		row_t rw;
		rw = '{default: '0};
		rw.cmd = cmd;
		rw.has_exp = has_exp;
		rw.exp_res = exp_res;
		return rw;
	endfunction

	initial begin
		logic [62:0] c;
		errors = 0;
		cycles = 0;
		beats_in = 0;
		beats_out = 0;
		hold_off = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		airmode_q = '0;
		for (int i = 0; i < NROT; i++) geom_q[i] = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (7) tick();
		arst_n <= 1'b1;
		tick();

		// Directed table. With all geometry zero after reset every demand is zero.
		table_rows.push_back(cmd_row({15'd16384, 16'h4000, 16'hC000, 16'h4000}, 1, '0));
		table_rows.push_back(cmd_row({15'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1, '0));
		// Pure thrust of one on rotor 0: a demand of exactly one, no flags.
		table_rows.push_back(cfg_row(mdm_pkg::REG_GEOM0, {16'sd8192, 48'd0}));
		table_rows.push_back(cmd_row({15'd16384, 48'd0}, 1, 74'd16384));
		// A quad-X frame through each airmode, the unused code included.
		table_rows.push_back(cfg_row(mdm_pkg::REG_GEOM0, 64'h2000_2000_E000_E000));
		table_rows.push_back(cfg_row(mdm_pkg::REG_GEOM1, 64'h2000_E000_2000_E000));
		table_rows.push_back(cfg_row(mdm_pkg::REG_GEOM2, 64'h2000_2000_2000_2000));
		table_rows.push_back(cfg_row(mdm_pkg::REG_GEOM3, 64'h2000_E000_E000_2000));
		for (int m = 0; m < 4; m++) begin
			table_rows.push_back(cfg_row(mdm_pkg::REG_AIRMODE, 64'(m)));
			table_rows.push_back(cmd_row({15'd8192, 16'h1000, 16'h0800, 16'h0400}, 0, '0));
			table_rows.push_back(cmd_row({15'd16384, 16'h4000, 16'h4000, 16'h4000}, 0, '0));
			table_rows.push_back(cmd_row({15'd0, 16'hC000, 16'hC000, 16'hC000}, 0, '0));
			table_rows.push_back(cmd_row({15'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF}, 0, '0));
		end
		// Extreme scales and an index past the register list, which is ignored.
		table_rows.push_back(cfg_row(REG_NONE, 64'hFFFF_FFFF_FFFF_FFFF));
		table_rows.push_back(cfg_row(mdm_pkg::REG_GEOM0, 64'h7FFF_8000_7FFF_8000));
		table_rows.push_back(cmd_row({15'h7FFF, 16'h8000, 16'h8000, 16'h7FFF}, 0, '0));

		send_idle_pct = 7;
		recv_idle_pct = 59;
		foreach (table_rows[n]) begin
			if (table_rows[n].is_cfg) begin
				drain();
				write_reg(table_rows[n].idx, table_rows[n].val);
			end else begin
				send_cmd(table_rows[n].cmd);
				if (table_rows[n].has_exp && motor_results_q[$] !== table_rows[n].exp_res) begin
					$display("%0t: table row %0d expected %h predicted %h", $time, n,
						table_rows[n].exp_res, motor_results_q[$]);
					errors++;
				end
			end
		end

		// Random phases: a fresh geometry and airmode each, three idling patterns.
		for (int ph = 0; ph < 30; ph++) begin
			drain();
			send_idle_pct = (ph < 10) ? 7 : (ph < 20 ? 59 : 0);
			recv_idle_pct = (ph < 10) ? 59 : (ph < 20 ? 7 : 0);
			write_reg(mdm_pkg::REG_AIRMODE, 64'($urandom_range(3, 0)));
			for (int r = 0; r < NROT; r++)
				write_reg(mdm_pkg::REG_GEOM0 + 3'(r), rand_geom(r));
			if (ph == 25) begin
				// Long receiver stall while commands keep coming.
				fork
					begin
						hold_off = 1'b1;
						repeat (6000) tick();
						hold_off = 1'b0;
					end
					for (int n = 0; n < 8; n++) send_cmd(rand_cmd());
				join
			end
			for (int n = 0; n < 50; n++) begin
				c = rand_cmd();
				send_cmd(c);
			end
		end

		drain();
		repeat (2200) tick();
		$display("Sent %0d command beats and checked %0d result beats over 30 settings", beats_in,
			beats_out);
		$display("covering all airmodes, extreme scales and commands, and a long output stall.");
		if (errors == 0 && motor_results_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
